@@ hw/rtl/lbps_pkg.sv @@
// Package for the LED blink pattern sequencer: item types, opcodes,
// register reset values and the two built-in pattern tables.
// No dependencies.
package lbps_pkg;

    localparam int CFG_W = 9;
    localparam int REP_W = 8;
    localparam int IDX_W = 4;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START_A = 2'd1;
    localparam logic [1:0] OP_START_B = 2'd2;

    localparam logic CFG_IDX_DOT  = 1'b0;
    localparam logic CFG_IDX_DASH = 1'b1;

    localparam logic [CFG_W-1:0] DOT_RESET  = 9'd150;
    localparam logic [CFG_W-1:0] DASH_RESET = 9'd400;

    localparam int LEN_A = 4;
    localparam int LEN_B = 12;

    // One bit per step, step 0 in bit 0.
    localparam logic [LEN_A-1:0] PAT_A_LONG = 4'b1100;
    localparam logic [LEN_A-1:0] PAT_A_LIT  = 4'b0101;
    localparam logic [LEN_B-1:0] PAT_B_LONG = 12'b1001_0001_0001;
    localparam logic [LEN_B-1:0] PAT_B_LIT  = 12'b0101_0101_0101;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [REP_W-1:0] repeat_count;
    } in_item_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
    } out_item_t;

    typedef struct packed {
        logic             is_long;
        logic             lit;
        logic             wrap;
        logic [IDX_W-1:0] next_index;
    } step_info_t;

endpackage

@@ hw/rtl/lbps_step_rom.sv @@
// Pattern step lookup: level and length of the current step, and the
// index that follows it. Depends on lbps_pkg.
module lbps_step_rom
    import lbps_pkg::*;
(
    input  logic             pattern_sel,
    input  logic [IDX_W-1:0] step_index,
    output step_info_t       info
);

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx_inc;

    always_comb
    begin
        info = '0;
        if (pattern_sel)
        begin
            // Fall back to step 0 on an out-of-range index
            idx = (step_index < IDX_W'(LEN_B)) ? step_index : '0;
            info.is_long = PAT_B_LONG[idx];
            info.lit     = PAT_B_LIT[idx];
            idx_inc      = idx + 1'b1;
            info.wrap    = (idx_inc >= IDX_W'(LEN_B));
        end
        else
        begin
            idx = (step_index < IDX_W'(LEN_A)) ? step_index : '0;
            info.is_long = PAT_A_LONG[idx[1:0]];
            info.lit     = PAT_A_LIT[idx[1:0]];
            idx_inc      = idx + 1'b1;
            info.wrap    = (idx_inc >= IDX_W'(LEN_A));
        end
        info.next_index = info.wrap ? '0 : idx_inc;
    end

endmodule

@@ hw/rtl/led_blink_pattern_sequencer.sv @@
// Top level of the LED blink pattern sequencer: sequencing state,
// duration registers and result register. Depends on lbps_pkg, lbps_step_rom.
//
// channel  direction  handshake             payload
// in       in         in_valid / in_ready   in_data  (opcode, repeat_count)
// out      out        out_valid / out_ready out_data (led_on, busy_res)
// cfg      in         cfg_we                cfg_index, cfg_data
//
// One item per cycle while in_ready is high; each item's result appears in the result
// register on the cycle after acceptance. The sequencing state updates in the same edge
// that accepts the item. in_ready drops only while a result is held unread and out_ready
// is low. Reset is asynchronous; no clearing pass is needed.
module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int DURATION_BITS = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int WIDE = (DURATION_BITS > CFG_W) ? DURATION_BITS : CFG_W;
    localparam logic [WIDE-1:0] DUR_MAX = WIDE'((33'd1 << DURATION_BITS) - 33'd1);

    logic [CFG_W-1:0]         dot_reg, dash_reg;
    logic                     playing_reg, playing_next;
    logic                     sel_reg, sel_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [REP_W-1:0]         target_reg, target_next;
    logic [REP_W-1:0]         done_reg, done_next;
    logic [DURATION_BITS-1:0] wait_reg, wait_next;
    logic                     led_reg, led_next;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    step_info_t               info;
    logic [WIDE-1:0]          dur_wide;
    logic [DURATION_BITS-1:0] dur_sat;
    logic [DURATION_BITS-1:0] wait_dec;
    logic [REP_W-1:0]         done_inc;
    logic                     accept;

    lbps_step_rom u_rom
    (
        .pattern_sel (sel_reg),
        .step_index  (idx_reg),
        .info        (info)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Saturate the step duration to what the wait counter holds
    always_comb
    begin
        dur_wide = WIDE'(info.is_long ? dash_reg : dot_reg);
        dur_sat  = (dur_wide > DUR_MAX) ? DUR_MAX[DURATION_BITS-1:0]
                                        : dur_wide[DURATION_BITS-1:0];
    end

    always_comb
    begin
        playing_next = playing_reg;
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        target_next  = target_reg;
        done_next    = done_reg;
        wait_next    = wait_reg;
        led_next     = led_reg;
        wait_dec     = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;
        done_inc     = done_reg + 1'b1;

        case (in_data.opcode)
            OP_START_A, OP_START_B:
            begin
                playing_next = 1'b1;
                sel_next     = (in_data.opcode == OP_START_B);
                idx_next     = '0;
                target_next  = in_data.repeat_count;
                done_next    = '0;
                wait_next    = '0;
            end
            OP_TICK:
            begin
                if (playing_reg)
                begin
                    wait_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        // Fire the current step
                        led_next  = info.lit;
                        wait_next = dur_sat;
                        idx_next  = info.next_index;
                        if (info.wrap)
                        begin
                            done_next = done_inc;
                            if (done_inc >= target_reg)
                                playing_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Hold the LED off while idle, unless a tick leaves the wait counter nonzero
        if (!playing_next && (in_data.opcode != OP_TICK || wait_next == '0))
            led_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= DOT_RESET;
            dash_reg <= DASH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_DOT:  dot_reg  <= cfg_data;
                CFG_IDX_DASH: dash_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            sel_reg     <= 1'b0;
            idx_reg     <= '0;
            target_reg  <= '0;
            done_reg    <= '0;
            wait_reg    <= '0;
            led_reg     <= 1'b0;
        end
        else if (accept)
        begin
            playing_reg <= playing_next;
            sel_reg     <= sel_next;
            idx_reg     <= idx_next;
            target_reg  <= target_next;
            done_reg    <= done_next;
            wait_reg    <= wait_next;
            led_reg     <= led_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.led_on   <= led_next;
            out_data_reg.busy_res <= playing_next;
        end
    end

endmodule
